// ===== hw/rtl/rsdz_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsdz_pkg
// Shared types and constants of the raw sample delta / zero-run encoder.
// ----------------------------------------------------------------------------
package rsdz_pkg;

    // Register indexes of the configuration port
    localparam logic [1:0] REG_QUANT_SHIFT    = 2'd0;
    localparam logic [1:0] REG_ZERO_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_BYTE_LIMIT     = 2'd2;

    // Reset values of the configuration registers
    localparam logic [2:0]  QUANT_SHIFT_RST    = 3'd0;
    localparam logic [6:0]  ZERO_THRESHOLD_RST = 7'd19;
    localparam logic [23:0] BYTE_LIMIT_RST     = 24'hFFFFFF;

    // Encoding constants
    localparam int          RUN_CHUNK_MAX = 65535;
    localparam int          HEADER_BYTES  = 16;
    localparam logic [7:0]  CODE_ROW      = 8'hFD;
    localparam logic [7:0]  CODE_ESC      = 8'hFF;
    localparam logic [7:0]  CODE_DELTA    = 8'hFE;
    localparam logic [7:0]  CODE_RUN      = 8'h00;
    localparam int          ITEM_BYTES    = 10;

    // Live configuration
    typedef struct packed {
        logic [2:0]  quant_shift;
        logic [6:0]  zero_threshold;
        logic [23:0] byte_limit;
    } rsdz_cfg_t;

    // One classified item: its payload bytes (slot 0 first) and abort flag
    typedef struct packed {
        logic [ITEM_BYTES-1:0][7:0] bytes;
        logic [3:0]                 nbytes;
        logic                       ovf;
    } rsdz_item_t;

endpackage

// ===== hw/rtl/rsdz_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsdz_if
// Valid/ready channels of the encoder: samples in, bytes out, register writes.
// ----------------------------------------------------------------------------
interface rsdz_sample_if;
    logic        valid;
    logic        ready;
    logic [15:0] sample;
    logic        first_in_frame;
    logic        first_in_row;
    logic [7:0]  row_number;
    logic        last_in_frame;

    modport source (output valid, sample, first_in_frame, first_in_row, row_number,
                    last_in_frame, input ready);
    modport sink   (input valid, sample, first_in_frame, first_in_row, row_number,
                    last_in_frame, output ready);
endinterface

interface rsdz_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_item;
    logic       overflow;

    modport source (output valid, out_byte, last_of_item, overflow, input ready);
    modport sink   (input valid, out_byte, last_of_item, overflow, output ready);
endinterface

interface rsdz_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [23:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/rsdz_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsdz_front
// Accepts samples, updates prediction, run and budget state, and builds the
// byte list of each transaction for the back end.
// ----------------------------------------------------------------------------
module rsdz_front (
    input  logic                clk,
    input  logic                rst_n,
    input  rsdz_pkg::rsdz_cfg_t cfg,
    input  logic                accept,
    input  logic [15:0]         sample,
    input  logic                first_in_frame,
    input  logic                first_in_row,
    input  logic [7:0]          row_number,
    input  logic                last_in_frame,
    output logic                push,
    output rsdz_pkg::rsdz_item_t item
);
    import rsdz_pkg::*;

    logic [15:0] prev_reg, prev_next;
    logic [15:0] run_reg, run_next;
    logic [23:0] count_reg, count_next;
    logic        abort_reg, abort_next;

    logic [23:0]        count_base;
    logic [15:0]        run_base;
    logic               abort_base;
    logic signed [24:0] avail;
    logic [15:0]        mask, cur, pred, diff;
    logic [16:0]        mag, run_inc;
    logic               is_zero, is_short;
    logic [15:0]        run_val;
    logic [3:0]         row_len, run_len, delta_len, delta_need, nbytes;
    logic               ovf;
    logic [15:0]        row_b;
    logic [31:0]        run_b, delta_b;
    logic [79:0]        pack;

    function automatic logic room(input logic signed [24:0] free, input logic [3:0] need);
        room = free >= $signed({21'd0, need});
    endfunction

    // Apply frame start and find free budget
    always_comb
    begin
        count_base = first_in_frame ? 24'(HEADER_BYTES) : count_reg;
        run_base   = first_in_frame ? 16'd0 : run_reg;
        abort_base = first_in_frame ? 1'b0 : abort_reg;
        avail      = $signed({1'b0, cfg.byte_limit}) - $signed({1'b0, count_base});
    end

    // Quantize, predict and classify the difference
    always_comb
    begin
        mask     = 16'hFFFF << cfg.quant_shift;
        cur      = sample & mask;
        pred     = first_in_row ? 16'd0 : prev_reg;
        diff     = cur - pred;
        mag      = diff[15] ? (17'h10000 - {1'b0, diff}) : {1'b0, diff};
        is_zero  = mag <= {10'd0, cfg.zero_threshold};
        is_short = mag <= 17'd127;
        run_inc  = {1'b0, run_base} + 17'd1;
        run_val  = is_zero ? run_inc[15:0] : run_base;
        delta_need = is_short ? 4'd1 : 4'd4;
    end

    // Walk the segments in order and stop at the first budget failure
    always_comb
    begin
        ovf       = 1'b0;
        row_len   = 4'd0;
        run_len   = 4'd0;
        delta_len = 4'd0;
        prev_next = prev_reg;
        run_next  = run_base;
        if (!abort_base)
        begin
            if (first_in_row && !room(avail, 4'd2))
            begin
                ovf = 1'b1;
            end
            else
            begin
                row_len   = first_in_row ? 4'd2 : 4'd0;
                prev_next = cur;
                if (is_zero)
                begin
                    run_next = run_inc[15:0];
                    if (run_inc >= 17'(RUN_CHUNK_MAX) || last_in_frame)
                    begin
                        if (room(avail, row_len + 4'd4))
                        begin
                            run_len  = (run_inc <= 17'd255) ? 4'd2 : 4'd4;
                            run_next = 16'd0;
                        end
                        else
                        begin
                            ovf = 1'b1;
                        end
                    end
                end
                else
                begin
                    if (run_base != 16'd0)
                    begin
                        if (room(avail, row_len + 4'd4))
                        begin
                            run_len  = (run_base <= 16'd255) ? 4'd2 : 4'd4;
                            run_next = 16'd0;
                        end
                        else
                        begin
                            ovf = 1'b1;
                        end
                    end
                    if (!ovf)
                    begin
                        if (room(avail, row_len + run_len + delta_need))
                            delta_len = delta_need;
                        else
                            ovf = 1'b1;
                    end
                end
            end
        end
        nbytes     = row_len + run_len + delta_len;
        abort_next = abort_base | ovf;
        count_next = count_base + {20'd0, nbytes};
    end

    // Assemble the byte list: row marker, run chunk, delta
    always_comb
    begin
        row_b = (row_len != 4'd0) ? {row_number, CODE_ROW} : 16'd0;
        unique case (run_len)
            4'd2:    run_b = {16'd0, run_val[7:0], CODE_RUN};
            4'd4:    run_b = {run_val[15:8], run_val[7:0], CODE_RUN, CODE_ESC};
            default: run_b = 32'd0;
        endcase
        unique case (delta_len)
            4'd1:    delta_b = {24'd0, diff[7:0]};
            4'd4:    delta_b = {diff[15:8], diff[7:0], CODE_DELTA, CODE_ESC};
            default: delta_b = 32'd0;
        endcase
        pack = {48'd0, delta_b};
        pack = (pack << {run_len, 3'b000}) | {48'd0, run_b};
        pack = (pack << {row_len, 3'b000}) | {64'd0, row_b};
    end

    assign item.bytes  = pack;
    assign item.nbytes = nbytes;
    assign item.ovf    = ovf;
    assign push        = accept && ((nbytes != 4'd0) || ovf);

    // Advance encoder state on each accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= 16'd0;
            run_reg   <= 16'd0;
            count_reg <= 24'(HEADER_BYTES);
            abort_reg <= 1'b0;
        end
        else if (accept)
        begin
            prev_reg  <= prev_next;
            run_reg   <= run_next;
            count_reg <= count_next;
            abort_reg <= abort_next;
        end
    end

endmodule

// ===== hw/rtl/rsdz_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsdz_queue
// Short first-in first-out buffer of classified items between front and back.
// ----------------------------------------------------------------------------
module rsdz_queue #(
    parameter int DEPTH = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  rsdz_pkg::rsdz_item_t push_item,
    output logic                 full,
    input  logic                 pop,
    output logic                 head_valid,
    output rsdz_pkg::rsdz_item_t head_item
);
    import rsdz_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    rsdz_item_t    slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full       = count_reg == CW'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head_item  = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Advance pointers with wrap at the depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the entry
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// ===== hw/rtl/rsdz_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsdz_back
// Serializes the head item into single-byte results through an output
// register, one result per cycle while byte_ch is ready.
// ----------------------------------------------------------------------------
module rsdz_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 head_valid,
    input  rsdz_pkg::rsdz_item_t head_item,
    output logic                 pop,
    rsdz_byte_if.source          byte_ch
);
    import rsdz_pkg::*;

    logic [3:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg;
    logic       last_reg, ovf_reg;
    logic       load, in_bytes, is_last;
    logic [3:0] total;
    logic [7:0] cur_byte;

    assign load     = head_valid && (!valid_reg || byte_ch.ready);
    assign in_bytes = idx_reg < head_item.nbytes;
    assign total    = head_item.nbytes + {3'd0, head_item.ovf};
    assign is_last  = idx_reg == (total - 4'd1);
    assign cur_byte = in_bytes ? head_item.bytes[idx_reg] : 8'd0;
    assign pop      = load && is_last;

    // Step through the item's results
    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg && !byte_ch.ready;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = is_last ? 4'd0 : idx_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 4'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= cur_byte;
            last_reg <= is_last;
            ovf_reg  <= !in_bytes;
        end
    end

    assign byte_ch.valid        = valid_reg;
    assign byte_ch.out_byte     = byte_reg;
    assign byte_ch.last_of_item = last_reg;
    assign byte_ch.overflow     = ovf_reg;

endmodule

// ===== hw/rtl/raw_sample_delta_zero_run_encoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raw_sample_delta_zero_run_encoder_core
// Delta and zero-run encoder of 16-bit raw sensor samples into a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   sample_ch takes one sample per transaction with its frame and row flags.
//   byte_ch returns the encoded bytes, one per transaction; last_of_item marks
//   the final byte caused by a sample, and overflow marks the single result
//   sent when the frame's byte budget runs out (the frame then stays silent
//   until the next first_in_frame). Samples that only extend a zero run give
//   no result at all.
//   cfg writes quant_shift (0), zero_threshold (1) and byte_limit (2); write
//   only while the encoder is idle. Other indexes are ignored.
// Timing:
//   The front end classifies a sample in the cycle it is accepted and can take
//   one sample every cycle while the item queue has room. The first byte
//   passes through the item queue and then the output register. The output
//   register sends one byte per cycle while byte_ch is ready; a sample gives at most 10 results.
// Reset and stall:
//   Reset restores the register defaults, clears prediction and run state and
//   sets the byte count to the header size. While byte_ch is stalled the
//   output holds, the queue fills, and sample_ch.ready drops once it is full.
// ----------------------------------------------------------------------------
module raw_sample_delta_zero_run_encoder_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    rsdz_sample_if.sink  sample_ch,
    rsdz_byte_if.source  byte_ch,
    rsdz_cfg_if.sink     cfg
);
    import rsdz_pkg::*;

    rsdz_cfg_t  cfg_reg;
    logic       accept, push, full, pop, head_valid;
    rsdz_item_t push_item, head_item;

    // Configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.quant_shift    <= QUANT_SHIFT_RST;
            cfg_reg.zero_threshold <= ZERO_THRESHOLD_RST;
            cfg_reg.byte_limit     <= BYTE_LIMIT_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_QUANT_SHIFT:    cfg_reg.quant_shift    <= cfg.data[2:0];
                REG_ZERO_THRESHOLD: cfg_reg.zero_threshold <= cfg.data[6:0];
                REG_BYTE_LIMIT:     cfg_reg.byte_limit     <= cfg.data;
                default:            ;
            endcase
        end
    end

    // Accept a sample whenever the queue has a free entry
    assign sample_ch.ready = !full;
    assign accept          = sample_ch.valid && !full;

    rsdz_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .accept         (accept),
        .sample         (sample_ch.sample),
        .first_in_frame (sample_ch.first_in_frame),
        .first_in_row   (sample_ch.first_in_row),
        .row_number     (sample_ch.row_number),
        .last_in_frame  (sample_ch.last_in_frame),
        .push           (push),
        .item           (push_item)
    );

    rsdz_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    rsdz_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .byte_ch    (byte_ch)
    );

endmodule

// ===== tb/rsdz_stream_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsdz_stream_checker
// Passive checker of the delta / zero-run encoder. It follows register writes
// and accepted samples, forecasts the encoded byte stream with its own copy of
// the encoder state, and compares every delivered byte field by field.
// ----------------------------------------------------------------------------
module rsdz_stream_checker (
    input  logic   clk,
    input  logic   rst_n,
    rsdz_sample_if sample_ch,
    rsdz_byte_if   byte_ch,
    rsdz_cfg_if    cfg_ch,
    output int     fail_count,
    output int     pending
);
    import rsdz_pkg::*;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_item;
        logic       overflow;
    } enc_byte_t;

    // Bytes still owed by the encoder, oldest first
    enc_byte_t   byte_forecast[$];
    // Bytes caused by the sample under evaluation
    enc_byte_t   item_bytes[$];
    enc_byte_t   want;

    // Shadow registers
    logic [2:0]  quant_shift;
    logic [6:0]  zero_threshold;
    logic [23:0] byte_limit;

    // Shadow encoder state
    logic [15:0] prev_level;
    int unsigned run_count;
    int unsigned bytes_used;
    bit          frame_dead;

    function automatic bit room_for(int unsigned need);
        return bytes_used + need <= byte_limit;
    endfunction

    function automatic void put_byte(logic [7:0] b);
        item_bytes.push_back('{out_byte: b, last_of_item: 1'b0, overflow: 1'b0});
        bytes_used = (bytes_used + 1) & 32'h00FF_FFFF;
    endfunction

    // Emit the pending zero run; the short form still reserves four bytes
    function automatic bit flush_pending_run();
        if (run_count == 0)
            return 1'b1;
        if (!room_for(4))
            return 1'b0;
        if (run_count <= 255)
        begin
            put_byte(CODE_RUN);
            put_byte(run_count[7:0]);
        end
        else
        begin
            put_byte(CODE_ESC);
            put_byte(CODE_RUN);
            put_byte(run_count[7:0]);
            put_byte(run_count[15:8]);
        end
        run_count = 0;
        return 1'b1;
    endfunction

    // Quantize, difference against the row prediction, then code
    function automatic bit code_level(logic [15:0] raw);
        logic [15:0] level;
        logic [15:0] delta;
        int unsigned mag;
        level      = raw & (16'hFFFF << quant_shift);
        delta      = level - prev_level;
        mag        = delta[15] ? 32'h0001_0000 - delta : delta;
        prev_level = level;
        if (mag <= zero_threshold)
        begin
            run_count++;
            if (run_count >= RUN_CHUNK_MAX)
                return flush_pending_run();
            return 1'b1;
        end
        if (!flush_pending_run())
            return 1'b0;
        if (mag <= 127)
        begin
            if (!room_for(1))
                return 1'b0;
            put_byte(delta[7:0]);
        end
        else
        begin
            if (!room_for(4))
                return 1'b0;
            put_byte(CODE_ESC);
            put_byte(CODE_DELTA);
            put_byte(delta[7:0]);
            put_byte(delta[15:8]);
        end
        return 1'b1;
    endfunction

    // Forecast the bytes of one sample transaction
    function automatic void encode_sample(logic [15:0] raw, logic frame_start,
                                          logic row_start, logic [7:0] row,
                                          logic frame_end);
        bit ok;
        ok = 1'b1;
        item_bytes.delete();
        if (frame_start)
        begin
            bytes_used = HEADER_BYTES;
            run_count  = 0;
            frame_dead = 1'b0;
        end
        // An aborted frame stays silent
        if (frame_dead)
            return;
        if (row_start)
        begin
            if (room_for(2))
            begin
                put_byte(CODE_ROW);
                put_byte(row);
                prev_level = '0;
            end
            else
                ok = 1'b0;
        end
        if (ok)
            ok = code_level(raw);
        if (ok && frame_end)
            ok = flush_pending_run();
        if (!ok)
        begin
            item_bytes.push_back('{out_byte: 8'h00, last_of_item: 1'b0, overflow: 1'b1});
            frame_dead = 1'b1;
        end
        if (item_bytes.size() > 0)
            item_bytes[item_bytes.size() - 1].last_of_item = 1'b1;
        foreach (item_bytes[i])
            byte_forecast.push_back(item_bytes[i]);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quant_shift    = QUANT_SHIFT_RST;
            zero_threshold = ZERO_THRESHOLD_RST;
            byte_limit     = BYTE_LIMIT_RST;
            prev_level     = '0;
            run_count      = 0;
            bytes_used     = HEADER_BYTES;
            frame_dead     = 1'b0;
            byte_forecast.delete();
            fail_count     = 0;
            pending        = 0;
        end
        else
        begin
            // Check the delivered byte before queueing new forecasts
            if (byte_ch.valid && byte_ch.ready)
            begin
                if (byte_forecast.size() == 0)
                begin
                    $error("unexpected byte transaction: out_byte %02h last_of_item %b overflow %b",
                           byte_ch.out_byte, byte_ch.last_of_item, byte_ch.overflow);
                    fail_count++;
                end
                else
                begin
                    want = byte_forecast.pop_front();
                    if (byte_ch.out_byte !== want.out_byte)
                    begin
                        $error("out_byte mismatch: expected %02h, actual %02h",
                               want.out_byte, byte_ch.out_byte);
                        fail_count++;
                    end
                    if (byte_ch.last_of_item !== want.last_of_item)
                    begin
                        $error("last_of_item mismatch: expected %b, actual %b",
                               want.last_of_item, byte_ch.last_of_item);
                        fail_count++;
                    end
                    if (byte_ch.overflow !== want.overflow)
                    begin
                        $error("overflow mismatch: expected %b, actual %b",
                               want.overflow, byte_ch.overflow);
                        fail_count++;
                    end
                end
            end

            // Follow register writes; unknown indexes are dropped
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_ch.index)
                    REG_QUANT_SHIFT:    quant_shift    = cfg_ch.data[2:0];
                    REG_ZERO_THRESHOLD: zero_threshold = cfg_ch.data[6:0];
                    REG_BYTE_LIMIT:     byte_limit     = cfg_ch.data[23:0];
                    default:            ;
                endcase
            end

            if (sample_ch.valid && sample_ch.ready)
                encode_sample(sample_ch.sample, sample_ch.first_in_frame,
                              sample_ch.first_in_row, sample_ch.row_number,
                              sample_ch.last_in_frame);

            pending = byte_forecast.size();
        end
    end

endmodule

// ===== tb/raw_sample_delta_zero_run_encoder_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raw_sample_delta_zero_run_encoder_core_tb
// Stimulus for the delta / zero-run encoder: a directed set of boundary
// deltas, row markers, run flushes and budget aborts, then random frames
// under several register settings with random gaps on the sample side and
// random stalls on the byte side. Checking is done by rsdz_stream_checker;
// this module drives and gives the verdict.
// ----------------------------------------------------------------------------
module raw_sample_delta_zero_run_encoder_core_tb;
    import rsdz_pkg::*;

    localparam int         CLK_HALF     = 4;
    localparam int         RESET_CYCLES = 5;
    localparam int         DRAIN_CYCLES = 16;
    localparam int         CYCLE_LIMIT  = 1_000_000;
    localparam int         FRAME_QUOTA  = 26;
    localparam logic [1:0] REG_SPARE    = 2'd3;

    typedef struct packed {
        logic [15:0] sample;
        logic        first_in_frame;
        logic        first_in_row;
        logic [7:0]  row_number;
        logic        last_in_frame;
    } pixel_t;

    typedef struct packed {
        logic [2:0]  shift;
        logic [6:0]  thresh;
        logic [23:0] limit;
    } reg_set_t;

    logic        clk;
    logic        rst_n;
    int          fail_count;
    int          pending;
    int          cycle_count;

    // Stimulus shaping state
    logic [2:0]  cur_shift;
    logic [6:0]  cur_thresh;
    logic [15:0] level;
    bit          steady;

    rsdz_sample_if sample_ch();
    rsdz_byte_if   byte_ch();
    rsdz_cfg_if    cfg_ch();

    raw_sample_delta_zero_run_encoder_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_ch),
        .byte_ch   (byte_ch),
        .cfg       (cfg_ch)
    );

    rsdz_stream_checker encode_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_ch  (sample_ch),
        .byte_ch    (byte_ch),
        .cfg_ch     (cfg_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
        clk = 1'b0;
    always #CLK_HALF clk = ~clk;

    // Mostly short gaps, a few long ones, none in a steady stretch
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 8);
        return $urandom_range(10, 40);
    endfunction

    function automatic pixel_t pix(logic [15:0] sample, int sof, int sor,
                                   logic [7:0] row, int eof);
        pixel_t px;
        px.sample         = sample;
        px.first_in_frame = sof[0];
        px.first_in_row   = sor[0];
        px.row_number     = row;
        px.last_in_frame  = eof[0];
        return px;
    endfunction

    // Walk the sample level by a delta of a random class
    function automatic logic [15:0] next_level(bit row_start);
        int unsigned unit;
        int unsigned mag;
        int          r;
        unit = 1 << cur_shift;
        if (row_start && $urandom_range(0, 1))
            level = 16'($urandom_range(0, (int'(cur_thresh) + 1) * unit));
        r = $urandom_range(0, 99);
        if (r < 40)
            mag = $urandom_range(0, int'(cur_thresh)) * unit;
        else if (r < 65)
            mag = $urandom_range(int'(cur_thresh) + 1, 127) * unit;
        else if (r < 75)
            mag = $urandom_range(126, 129) * unit;
        else if (r < 90)
            mag = $urandom_range(0, 65535);
        else
        begin
            level = 16'($urandom_range(0, 65535));
            mag   = 0;
        end
        if ($urandom_range(0, 1))
            level = level + mag[15:0];
        else
            level = level - mag[15:0];
        // Low bits below the quantization step are random and must not matter
        return level ^ 16'(($urandom & (unit - 1)));
    endfunction

    // Present one sample and hold it until accepted
    task automatic send_pixel(pixel_t px);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid          <= 1'b1;
        sample_ch.sample         <= px.sample;
        sample_ch.first_in_frame <= px.first_in_frame;
        sample_ch.first_in_row   <= px.first_in_row;
        sample_ch.row_number     <= px.row_number;
        sample_ch.last_in_frame  <= px.last_in_frame;
        do
            @(posedge clk);
        while (!sample_ch.ready);
    endtask

    // Drop valid, drain all forecast bytes, then let silent work settle
    task automatic wait_idle();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write every register, with junk above the used bits, plus a spare index
    task automatic write_regs(logic [2:0] shift, logic [6:0] thresh, logic [23:0] limit);
        logic [1:0]  idx [4];
        logic [23:0] val [4];
        idx[0] = REG_QUANT_SHIFT;
        idx[1] = REG_ZERO_THRESHOLD;
        idx[2] = REG_BYTE_LIMIT;
        idx[3] = REG_SPARE;
        val[0] = 24'(($urandom & 32'h00FF_FFF8) | shift);
        val[1] = 24'(($urandom & 32'h00FF_FF80) | thresh);
        val[2] = limit;
        val[3] = 24'($urandom);
        for (int i = 0; i < 4; i++)
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idx[i];
            cfg_ch.data  <= val[i];
            do
                @(posedge clk);
            while (!cfg_ch.ready);
        end
        cfg_ch.valid <= 1'b0;
        cur_shift  = shift;
        cur_thresh = thresh;
    endtask

    // Well-formed frames with random content, some broken flags and noise
    task automatic send_frames(int quota);
        int     sent;
        int     rows;
        int     len;
        int     row0;
        pixel_t px;
        sent = 0;
        while (sent < quota)
        begin
            steady = ($urandom_range(0, 4) == 0);
            rows   = $urandom_range(1, 4);
            row0   = $urandom_range(0, 255);
            for (int r = 0; r < rows && sent < quota; r++)
            begin
                len = $urandom_range(1, 10);
                for (int i = 0; i < len && sent < quota; i++)
                begin
                    px = pix(16'h0000, int'(r == 0 && i == 0), int'(i == 0), 8'(row0 + r),
                             int'(r == rows - 1 && i == len - 1));
                    px.sample = next_level(px.first_in_row);
                    if ($urandom_range(0, 19) == 0)
                    begin
                        case ($urandom_range(0, 2))
                            0:       px.first_in_frame = ~px.first_in_frame;
                            1:       px.first_in_row   = ~px.first_in_row;
                            default: px.last_in_frame  = ~px.last_in_frame;
                        endcase
                    end
                    if ($urandom_range(0, 11) == 0)
                        px = pix(16'($urandom), $urandom_range(0, 1), $urandom_range(0, 1),
                                 8'($urandom), $urandom_range(0, 1));
                    send_pixel(px);
                    sent++;
                end
            end
        end
        steady = 1'b0;
    endtask

    // Byte side: ready bursts broken by random stalls
    initial
    begin
        int burst;
        int stall;
        byte_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            burst = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200)
                                                 : $urandom_range(1, 6);
            byte_ch.ready <= 1'b1;
            repeat (burst) @(posedge clk);
            stall = pick_gap();
            if (stall > 0)
            begin
                byte_ch.ready <= 1'b0;
                repeat (stall - 1) @(posedge clk);
            end
        end
    end

    // Watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        reg_set_t plan [7];

        rst_n                    = 1'b0;
        sample_ch.valid          = 1'b0;
        sample_ch.sample         = '0;
        sample_ch.first_in_frame = 1'b0;
        sample_ch.first_in_row   = 1'b0;
        sample_ch.row_number     = '0;
        sample_ch.last_in_frame  = 1'b0;
        cfg_ch.valid             = 1'b0;
        cfg_ch.index             = REG_QUANT_SHIFT;
        cfg_ch.data              = '0;
        steady                   = 1'b0;
        cur_shift                = QUANT_SHIFT_RST;
        cur_thresh               = ZERO_THRESHOLD_RST;
        level                    = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Reset defaults: delta boundaries, escapes, row markers, run flushes
        send_pixel(pix(16'h0000, 1, 1, 8'h00, 0));
        send_pixel(pix(16'h0014, 0, 0, 8'h00, 0));
        send_pixel(pix(16'h0027, 0, 0, 8'h00, 0));
        send_pixel(pix(16'h00A6, 0, 0, 8'h00, 0));
        send_pixel(pix(16'h0027, 0, 0, 8'h00, 0));
        send_pixel(pix(16'h00A7, 0, 0, 8'h00, 0));
        send_pixel(pix(16'h0027, 0, 0, 8'h00, 0));
        send_pixel(pix(16'h8000, 0, 1, 8'hFF, 0));
        send_pixel(pix(16'h7FFF, 0, 1, 8'hAA, 0));
        send_pixel(pix(16'h7FEC, 0, 0, 8'h00, 0));
        // Run stays pending across the row start
        send_pixel(pix(16'h0013, 0, 1, 8'h55, 0));
        send_pixel(pix(16'hFFFF, 0, 0, 8'h00, 1));
        send_pixel(pix(16'hFFFF, 1, 0, 8'h00, 1));
        wait_idle();

        // Tight budget: each kind of abort, silence, and recovery
        write_regs(3'd0, 7'd19, 24'd20);
        send_pixel(pix(16'h4000, 1, 1, 8'h3C, 0));
        send_pixel(pix(16'h1111, 0, 1, 8'h01, 1));
        send_pixel(pix(16'h4032, 1, 0, 8'h00, 0));
        send_pixel(pix(16'h4032, 0, 0, 8'h00, 0));
        send_pixel(pix(16'h4096, 0, 0, 8'h00, 0));
        send_pixel(pix(16'h0000, 1, 1, 8'h02, 1));
        send_pixel(pix(16'h001E, 1, 0, 8'h00, 0));
        send_pixel(pix(16'h003C, 0, 0, 8'h00, 0));
        send_pixel(pix(16'h005A, 0, 0, 8'h00, 0));
        send_pixel(pix(16'h0000, 0, 1, 8'h07, 0));
        send_pixel(pix(16'h1234, 1, 0, 8'h00, 0));
        send_pixel(pix(16'h1234, 0, 0, 8'h00, 1));
        wait_idle();

        // Random frames under several settings, extremes included
        plan[0] = '{shift: 3'd0, thresh: 7'd0,   limit: 24'hFF_FFFF};
        plan[1] = '{shift: 3'd7, thresh: 7'd127, limit: 24'd64};
        plan[2] = '{shift: 3'd2, thresh: 7'd1,   limit: 24'd200};
        plan[3] = '{shift: 3'd4, thresh: 7'd80,  limit: 24'($urandom_range(64, 160))};
        plan[4] = '{shift: 3'd5, thresh: 7'd40,  limit: 24'd17};
        plan[5] = '{shift: 3'd1, thresh: 7'd10,  limit: 24'($urandom_range(300, 5000))};
        plan[6] = '{shift: 3'd6, thresh: 7'd19,  limit: 24'($urandom_range(100, 400))};
        foreach (plan[i])
        begin
            write_regs(plan[i].shift, plan[i].thresh, plan[i].limit);
            send_frames(FRAME_QUOTA);
            wait_idle();
        end

        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
